// ===== sv/tac_pkg.sv =====
`default_nettype none
package tac_pkg;

    // ln 2 in q32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // 100 * 2^48, the dividend of the kelvin reciprocal in hundredths
    localparam logic [54:0] HUNDRED_Q48 = 55'd100 << 48;

    // reciprocal of 100 scaled by 2^30, rounded up, exact for values below 2^23
    localparam logic [23:0] RECIP_100 = 24'd10737419;

    // configuration register indexes
    localparam logic [2:0] REG_LSB_FRACTION = 3'd0;
    localparam logic [2:0] REG_PULLUP_OHMS  = 3'd1;
    localparam logic [2:0] REG_COEFF_A      = 3'd2;
    localparam logic [2:0] REG_COEFF_B      = 3'd3;
    localparam logic [2:0] REG_COEFF_C      = 3'd4;
    localparam logic [2:0] REG_COEFF_D      = 3'd5;
    localparam logic [2:0] REG_ERROR_TEMP   = 3'd6;

    // flags that travel with each transaction down the chain
    typedef struct packed {
        logic       invalid;
        logic       ovf;
        logic       s_zero;
        logic       s_huge;
        logic       s_neg;
        logic [5:0] msb;
    } t_side;

endpackage
`default_nettype wire

// ===== sv/tac_div_cell.sv =====
`default_nettype none
module tac_div_cell import tac_pkg::*; #(
    parameter int W  = 32,
    parameter int QW = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [W-1:0]  i_rem,
    input  logic [W-1:0]  i_den,
    input  logic [QW-1:0] i_quo,
    input  t_side         i_side,
    output logic          o_valid,
    output logic [W-1:0]  o_rem,
    output logic [W-1:0]  o_den,
    output logic [QW-1:0] o_quo,
    output t_side         o_side
);

    logic          r_valid;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_den;
    logic [QW-1:0] r_quo;
    t_side         r_side;

    logic [W:0] w_trial;
    logic [W:0] w_diff;
    logic       w_ge;

    // one restoring step: bring in the next dividend bit, try the subtract
    assign w_trial = {i_rem, i_quo[QW-1]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_ge    = (w_trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // remainder, divisor and quotient/dividend shift word
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
            r_den  <= i_den;
            r_quo  <= {i_quo[QW-2:0], w_ge};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule
`default_nettype wire

// ===== sv/tac_ln_cell.sv =====
`default_nettype none
module tac_ln_cell import tac_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_m,
    input  logic [31:0] i_f,
    input  t_side       i_side,
    output logic        o_valid,
    output logic [31:0] o_m,
    output logic [31:0] o_f,
    output t_side       o_side
);

    logic        r_valid;
    logic [31:0] r_m;
    logic [31:0] r_f;
    t_side       r_side;

    logic [63:0] w_sq;
    logic [32:0] w_top;

    // square the mantissa, a carry past 2 gives the next log2 fraction bit
    assign w_sq  = i_m * i_m;
    assign w_top = w_sq[63:31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m    <= w_top[32] ? w_top[32:1] : w_top[31:0];
            r_f    <= {i_f[30:0], w_top[32]};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_m     = r_m;
    assign o_f     = r_f;
    assign o_side  = r_side;

endmodule
`default_nettype wire

// ===== sv/tac_horner_cell.sv =====
`default_nettype none
module tac_horner_cell import tac_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [63:0] i_acc,
    input  logic signed [38:0] i_l,
    input  logic signed [47:0] i_coef,
    input  t_side              i_side,
    output logic               o_valid,
    output logic signed [63:0] o_acc,
    output logic signed [38:0] o_l,
    output t_side              o_side
);

    logic               r1_valid;
    logic signed [71:0] r1_pl;
    logic signed [70:0] r1_ph;
    logic signed [38:0] r1_l;
    t_side              r1_side;

    logic               r2_valid;
    logic signed [63:0] r2_acc;
    logic signed [38:0] r2_l;
    t_side              r2_side;

    logic               r3_valid;
    logic signed [63:0] r3_acc;
    logic signed [38:0] r3_l;
    t_side              r3_side;

    logic signed [71:0] w_pl;
    logic signed [70:0] w_ph;
    logic        [72:0] w_sum;
    logic        [63:0] w_prod_sat;
    logic        [64:0] w_add;
    logic        [63:0] w_add_sat;

    // partial products of the low and high halves of the accumulator
    assign w_pl = $signed({1'b0, i_acc[31:0]}) * i_l;
    assign w_ph = $signed(i_acc[63:32]) * i_l;

    // floor of the product over 2^32, saturated to 64 bits
    assign w_sum = {{2{r1_ph[70]}}, r1_ph} + {{33{r1_pl[71]}}, r1_pl[71:32]};
    always_comb begin
        if ((w_sum[72:63] == 10'h000) || (w_sum[72:63] == 10'h3ff)) begin
            w_prod_sat = w_sum[63:0];
        end else if (w_sum[72]) begin
            w_prod_sat = {1'b1, 63'h0};
        end else begin
            w_prod_sat = {1'b0, {63{1'b1}}};
        end
    end

    // add the coefficient, saturated
    assign w_add = {r2_acc[63], r2_acc} + {{17{i_coef[47]}}, i_coef};
    always_comb begin
        if (w_add[64] == w_add[63]) begin
            w_add_sat = w_add[63:0];
        end else if (w_add[64]) begin
            w_add_sat = {1'b1, 63'h0};
        end else begin
            w_add_sat = {1'b0, {63{1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pl   <= w_pl;
            r1_ph   <= w_ph;
            r1_l    <= i_l;
            r1_side <= i_side;
            r2_acc  <= $signed(w_prod_sat);
            r2_l    <= r1_l;
            r2_side <= r1_side;
            r3_acc  <= $signed(w_add_sat);
            r3_l    <= r2_l;
            r3_side <= r2_side;
        end
    end

    assign o_valid = r3_valid;
    assign o_acc   = r3_acc;
    assign o_l     = r3_l;
    assign o_side  = r3_side;

endmodule
`default_nettype wire

// ===== sv/thermistor_adc_to_celsius.sv =====
`default_nettype none
// channel   | valid / ready             | payload
// ----------+---------------------------+-------------------------------
// in        | i_in_valid / o_in_ready   | i_adc_reading
// out       | o_out_valid / i_out_ready | o_temp_celsius, o_invalid
// config    | psel, penable, pwrite     | paddr, pwdata, prdata (8-byte regs)
//
// one reading enters every cycle while the skid register is empty; a result
// passes through the two chains of one-bit divider cells (64 and
// 55), the 32 log squaring cells and the three 3-stage horner cells.
// synchronous active-low reset sets config to its defaults and clears all valid bits.
// a stalled output fills a one-entry skid register; only then is input held.
module thermistor_adc_to_celsius import tac_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_adc_reading,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_temp_celsius,
    output logic               o_invalid,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    localparam int DIV1_N = 64;
    localparam int LN_N   = 32;
    localparam int HORN_N = 3;
    localparam int DIV2_N = 55;

    // configuration registers
    logic [31:0]        r_lsb_fraction;
    logic [23:0]        r_pullup_ohms;
    logic signed [47:0] r_coeff_a;
    logic signed [47:0] r_coeff_b;
    logic signed [47:0] r_coeff_c;
    logic signed [47:0] r_coeff_d;
    logic signed [15:0] r_error_temp;

    logic       w_cfg_wr;
    logic [2:0] w_cfg_idx;
    logic       w_en;

    // front stages
    logic        r1_valid;
    logic [46:0] r1_ratio;
    logic        r1_inv;
    logic        r2_valid;
    logic [55:0] r2_num;
    logic [31:0] r2_den;
    logic        r2_inv;
    logic        w_inv2;
    t_side       w_side_d1;

    // divider chain for the resistance
    logic        d1_valid [0:DIV1_N];
    logic [31:0] d1_rem   [0:DIV1_N];
    logic [31:0] d1_den   [0:DIV1_N];
    logic [63:0] d1_quo   [0:DIV1_N];
    t_side       d1_side  [0:DIV1_N];

    logic        r3_valid;
    logic [63:0] r3_res;
    t_side       r3_side;
    logic        r4_valid;
    logic [63:0] r4_res;
    t_side       r4_side;
    t_side       w_side4;
    logic [5:0]  w_msb;
    logic [63:0] w_norm;
    logic        r5_valid;
    logic [31:0] r5_m;
    t_side       r5_side;
    t_side       w_side5;

    // log squaring chain
    logic        l_valid [0:LN_N];
    logic [31:0] l_m     [0:LN_N];
    logic [31:0] l_f     [0:LN_N];
    t_side       l_side  [0:LN_N];

    logic signed [6:0]  w_pm16;
    logic signed [39:0] w_lp;
    logic [63:0]        w_lf;
    logic               r6_valid;
    logic signed [39:0] r6_lp;
    logic [31:0]        r6_lf;
    t_side              r6_side;
    logic [39:0]        w_lsum;
    logic               r7_valid;
    logic signed [38:0] r7_l;
    t_side              r7_side;

    // horner chain
    logic               h_valid [0:HORN_N];
    logic signed [63:0] h_acc   [0:HORN_N];
    logic signed [38:0] h_l     [0:HORN_N];
    t_side              h_side  [0:HORN_N];
    logic signed [47:0] w_coef  [0:HORN_N-1];

    logic [63:0] w_us;
    t_side       w_side8;
    logic        r8_valid;
    logic [49:0] r8_us;
    t_side       r8_side;

    // divider chain for the reciprocal
    logic        d2_valid [0:DIV2_N];
    logic [49:0] d2_rem   [0:DIV2_N];
    logic [49:0] d2_den   [0:DIV2_N];
    logic [54:0] d2_quo   [0:DIV2_N];
    t_side       d2_side  [0:DIV2_N];

    logic [54:0] w_q;
    logic [24:0] w_t;
    logic [22:0] w_u;
    logic        w_neg;
    logic        r9_valid;
    logic [22:0] r9_u;
    logic        r9_neg;
    t_side       r9_side;
    logic        r10_valid;
    logic [46:0] r10_prod;
    logic        r10_neg;
    t_side       r10_side;
    logic [16:0] w_quot;
    logic signed [15:0] w_temp;

    // output register and skid
    logic               r_out_valid;
    logic signed [15:0] r_out_temp;
    logic               r_out_inv;
    logic               r_skid_full;
    logic signed [15:0] r_skid_temp;
    logic               r_skid_inv;
    logic               w_take;

    // configuration port
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[5:3];
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsb_fraction <= 32'd65536;
            r_pullup_ohms  <= 24'd10000;
            r_coeff_a      <= '0;
            r_coeff_b      <= '0;
            r_coeff_c      <= '0;
            r_coeff_d      <= '0;
            r_error_temp   <= -16'sd32768;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_LSB_FRACTION: r_lsb_fraction <= pwdata[31:0];
                REG_PULLUP_OHMS:  r_pullup_ohms  <= pwdata[23:0];
                REG_COEFF_A:      r_coeff_a      <= $signed(pwdata[47:0]);
                REG_COEFF_B:      r_coeff_b      <= $signed(pwdata[47:0]);
                REG_COEFF_C:      r_coeff_c      <= $signed(pwdata[47:0]);
                REG_COEFF_D:      r_coeff_d      <= $signed(pwdata[47:0]);
                REG_ERROR_TEMP:   r_error_temp   <= $signed(pwdata[15:0]);
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (w_cfg_idx)
            REG_LSB_FRACTION: prdata = {32'h0, r_lsb_fraction};
            REG_PULLUP_OHMS:  prdata = {40'h0, r_pullup_ohms};
            REG_COEFF_A:      prdata = {16'h0, r_coeff_a};
            REG_COEFF_B:      prdata = {16'h0, r_coeff_b};
            REG_COEFF_C:      prdata = {16'h0, r_coeff_c};
            REG_COEFF_D:      prdata = {16'h0, r_coeff_d};
            REG_ERROR_TEMP:   prdata = {48'h0, r_error_temp};
            default:          prdata = '0;
        endcase
    end

    // the whole chain advances unless the skid holds a result
    assign w_en       = ~r_skid_full;
    assign o_in_ready = w_en;

    // stage 1: divider ratio
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ratio <= r_lsb_fraction * i_adc_reading[14:0];
            r1_inv   <= i_adc_reading[15] | (i_adc_reading == 16'sd0);
        end
    end

    // stage 2: numerator and denominator of the resistance
    assign w_inv2 = r1_inv | (r1_ratio == 47'd0) | (r1_ratio[46:32] != 15'd0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_num <= r_pullup_ohms * r1_ratio[31:0];
            r2_den <= 32'd0 - r1_ratio[31:0];
            r2_inv <= w_inv2;
        end
    end

    // resistance divider: quotient of num*2^16 over den, overflow seen up front
    always_comb begin
        w_side_d1         = '0;
        w_side_d1.invalid = r2_inv;
        w_side_d1.ovf     = ({24'h0, r2_num[55:48]} >= r2_den);
    end

    assign d1_valid[0] = r2_valid;
    assign d1_rem[0]   = {24'h0, r2_num[55:48]};
    assign d1_den[0]   = r2_den;
    assign d1_quo[0]   = {r2_num[47:0], 16'h0};
    assign d1_side[0]  = w_side_d1;

    for (genvar k = 0; k < DIV1_N; k++) begin : g_div1
        tac_div_cell #(.W(32), .QW(64)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (d1_valid[k]),
            .i_rem   (d1_rem[k]),
            .i_den   (d1_den[k]),
            .i_quo   (d1_quo[k]),
            .i_side  (d1_side[k]),
            .o_valid (d1_valid[k+1]),
            .o_rem   (d1_rem[k+1]),
            .o_den   (d1_den[k+1]),
            .o_quo   (d1_quo[k+1]),
            .o_side  (d1_side[k+1])
        );
    end

    // stage 3: saturate and clamp the resistance
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (d1_side[DIV1_N].ovf) begin
                r3_res <= '1;
            end else if (d1_quo[DIV1_N] == 64'd0) begin
                r3_res <= 64'd1;
            end else begin
                r3_res <= d1_quo[DIV1_N];
            end
            r3_side <= d1_side[DIV1_N];
        end
    end

    // stage 4: leading one of the resistance
    always_comb begin
        w_msb = '0;
        for (int i = 0; i < 64; i++) begin
            if (r3_res[i]) begin
                w_msb = 6'(i);
            end
        end
    end

    always_comb begin
        w_side4     = r3_side;
        w_side4.msb = w_msb;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_res  <= r3_res;
            r4_side <= w_side4;
        end
    end

    // stage 5: normalise to a q1.31 mantissa
    assign w_norm = r4_res << (6'd63 - r4_side.msb);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_m    <= w_norm[63:32];
            r5_side <= r4_side;
        end
    end

    assign w_side5 = r5_side;

    assign l_valid[0] = r5_valid;
    assign l_m[0]     = r5_m;
    assign l_f[0]     = '0;
    assign l_side[0]  = w_side5;

    for (genvar k = 0; k < LN_N; k++) begin : g_ln
        tac_ln_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (l_valid[k]),
            .i_m     (l_m[k]),
            .i_f     (l_f[k]),
            .i_side  (l_side[k]),
            .o_valid (l_valid[k+1]),
            .o_m     (l_m[k+1]),
            .o_f     (l_f[k+1]),
            .o_side  (l_side[k+1])
        );
    end

    // stage 6: scale exponent and fraction by ln 2
    assign w_pm16 = $signed({1'b0, l_side[LN_N].msb}) - 7'sd16;
    assign w_lp   = w_pm16 * $signed({1'b0, LN2_Q32});
    assign w_lf   = l_f[LN_N] * LN2_Q32;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_lp   <= w_lp;
            r6_lf   <= w_lf[63:32];
            r6_side <= l_side[LN_N];
        end
    end

    // stage 7: natural log in q32
    assign w_lsum = r6_lp + {8'h0, r6_lf};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_l    <= $signed(w_lsum[38:0]);
            r7_side <= r6_side;
        end
    end

    // horner evaluation, d first then c, b, a
    assign w_coef[0] = r_coeff_c;
    assign w_coef[1] = r_coeff_b;
    assign w_coef[2] = r_coeff_a;

    assign h_valid[0] = r7_valid;
    assign h_acc[0]   = {{16{r_coeff_d[47]}}, r_coeff_d};
    assign h_l[0]     = r7_l;
    assign h_side[0]  = r7_side;

    for (genvar k = 0; k < HORN_N; k++) begin : g_horner
        tac_horner_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (h_valid[k]),
            .i_acc   (h_acc[k]),
            .i_l     (h_l[k]),
            .i_coef  (w_coef[k]),
            .i_side  (h_side[k]),
            .o_valid (h_valid[k+1]),
            .o_acc   (h_acc[k+1]),
            .o_l     (h_l[k+1]),
            .o_side  (h_side[k+1])
        );
    end

    // stage 8: magnitude of the sum and its special cases
    assign w_us = h_acc[HORN_N][63] ? (64'd0 - h_acc[HORN_N]) : h_acc[HORN_N];

    always_comb begin
        w_side8        = h_side[HORN_N];
        w_side8.s_zero = (h_acc[HORN_N] == 64'sd0);
        w_side8.s_huge = (w_us[63:50] != 14'd0);
        w_side8.s_neg  = h_acc[HORN_N][63];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_us   <= w_us[49:0];
            r8_side <= w_side8;
        end
    end

    // reciprocal divider: 100*2^48 over the sum magnitude
    assign d2_valid[0] = r8_valid;
    assign d2_rem[0]   = '0;
    assign d2_den[0]   = r8_us;
    assign d2_quo[0]   = HUNDRED_Q48;
    assign d2_side[0]  = r8_side;

    for (genvar k = 0; k < DIV2_N; k++) begin : g_div2
        tac_div_cell #(.W(50), .QW(55)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (d2_valid[k]),
            .i_rem   (d2_rem[k]),
            .i_den   (d2_den[k]),
            .i_quo   (d2_quo[k]),
            .i_side  (d2_side[k]),
            .o_valid (d2_valid[k+1]),
            .o_rem   (d2_rem[k+1]),
            .o_den   (d2_den[k+1]),
            .o_quo   (d2_quo[k+1]),
            .o_side  (d2_side[k+1])
        );
    end

    // stage 9: offset to celsius, set up magnitude for the rounding divide
    assign w_q = d2_quo[DIV2_N];

    always_comb begin
        w_t   = '0;
        w_u   = '0;
        w_neg = 1'b0;
        if (w_q[54:22] != 33'd0) begin
            w_u   = 23'd4194304;
            w_neg = d2_side[DIV2_N].s_neg;
        end else if (d2_side[DIV2_N].s_neg) begin
            w_u   = {1'b0, w_q[21:0]} + 23'd27365;
            w_neg = 1'b1;
        end else if (d2_rem[DIV2_N] != 50'd0) begin
            w_t = {3'b0, w_q[21:0]} - 25'd27265;
            if (!w_t[24]) begin
                w_u = w_t[22:0];
            end else begin
                w_t   = 25'd99 - w_t;
                w_u   = w_t[22:0];
                w_neg = 1'b1;
            end
        end else begin
            w_t = {3'b0, w_q[21:0]} - 25'd27315;
            if (!w_t[24]) begin
                w_t = w_t + 25'd50;
                w_u = w_t[22:0];
            end else begin
                w_t   = 25'd50 - w_t;
                w_u   = w_t[22:0];
                w_neg = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_u    <= w_u;
            r9_neg  <= w_neg;
            r9_side <= d2_side[DIV2_N];
        end
    end

    // stage 10: divide by 100 through the reciprocal
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_prod <= r9_u * RECIP_100;
            r10_neg  <= r9_neg;
            r10_side <= r9_side;
        end
    end

    // final sign, saturation and special results
    assign w_quot = r10_prod[46:30];

    always_comb begin
        if (r10_side.invalid) begin
            w_temp = r_error_temp;
        end else if (r10_side.s_zero) begin
            w_temp = 16'sd32767;
        end else if (r10_side.s_huge) begin
            w_temp = -16'sd273;
        end else if (r10_neg) begin
            if (w_quot > 17'd32768) begin
                w_temp = -16'sd32768;
            end else begin
                w_temp = $signed(16'd0 - w_quot[15:0]);
            end
        end else if (w_quot > 17'd32767) begin
            w_temp = 16'sd32767;
        end else begin
            w_temp = $signed(w_quot[15:0]);
        end
    end

    // valid bits of the front and glue stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid  <= 1'b0;
            r2_valid  <= 1'b0;
            r3_valid  <= 1'b0;
            r4_valid  <= 1'b0;
            r5_valid  <= 1'b0;
            r6_valid  <= 1'b0;
            r7_valid  <= 1'b0;
            r8_valid  <= 1'b0;
            r9_valid  <= 1'b0;
            r10_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid  <= i_in_valid;
            r2_valid  <= r1_valid;
            r3_valid  <= d1_valid[DIV1_N];
            r4_valid  <= r3_valid;
            r5_valid  <= r4_valid;
            r6_valid  <= l_valid[LN_N];
            r7_valid  <= r6_valid;
            r8_valid  <= h_valid[HORN_N];
            r9_valid  <= d2_valid[DIV2_N];
            r10_valid <= r9_valid;
        end
    end

    // output register with one-entry skid
    assign w_take = r_out_valid & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else begin
            if (r_skid_full) begin
                if (w_take) begin
                    r_skid_full <= 1'b0;
                end
            end else if (w_en && r10_valid) begin
                if (r_out_valid && !w_take) begin
                    r_skid_full <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (w_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_full) begin
            if (w_take) begin
                r_out_temp <= r_skid_temp;
                r_out_inv  <= r_skid_inv;
            end
        end else if (w_en && r10_valid) begin
            if (r_out_valid && !w_take) begin
                r_skid_temp <= w_temp;
                r_skid_inv  <= r10_side.invalid;
            end else begin
                r_out_temp <= w_temp;
                r_out_inv  <= r10_side.invalid;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_temp_celsius = r_out_temp;
    assign o_invalid      = r_out_inv;

    // a full skid always sits behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_full |-> r_out_valid)
        else $error("skid holds a result with the output register empty");

    // draining the skid leaves a result in the output register
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_full && i_out_ready) |=> r_out_valid)
        else $error("result lost while draining the skid");

    // a flagged result carries the configured error temperature
    a_invalid_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_inv) |-> (r_out_temp == r_error_temp))
        else $error("invalid result without the error temperature");

endmodule
`default_nettype wire
